// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffza_pkg.sv =====
`timescale 1ns / 1ps
package ffza_pkg;
  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int ZONE_ALIGN   = 8;
  localparam int ZONE_SLOTS   = POOL_BYTES / ZONE_ALIGN;
  localparam int SLOT_W       = $clog2(ZONE_SLOTS);
  localparam int OFF_W        = $clog2(POOL_BYTES) + 2;
  localparam int SIZE_W       = 13;
  localparam int WALK_LIMIT   = POOL_BYTES - HEADER_BYTES;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_NOZONE  = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } zone_hdr_t;

  typedef struct packed {
    logic        kind;
    logic [12:0] req_size;
    logic [3:0]  align_log2;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
    logic [12:0] granted_size;
  } rsp_t;
endpackage

// ===== rtl/ffza_if.sv =====
`timescale 1ns / 1ps
interface ffza_req_if (input logic clk);
  logic           valid;
  logic           ready;
  ffza_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ffza_rsp_if (input logic clk);
  logic           valid;
  logic           ready;
  ffza_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/first_fit_zone_allocator.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Word
// in      | in  | kind, req_size, align_log2, free_address
// out     | out | status, address, granted_size
// cfg     | in  | pool_base (write enable + data)
// Walk one header at a time (address out, header back); after the accept an alloc
// walks to the first fit, writes its header and any split, then gives the result.
// A free walks the same way to its zone, then merges the free zones that follow.
// Reset (synchronous, rst_n low) starts a pass that clears the store one slot per
// cycle and sets slot 0 free over the pool; no word is taken before it ends.
// A result waits in the output register; the next word is taken once it leaves.
module first_fit_zone_allocator (
  input  logic           clk,
  input  logic           rst_n,
  ffza_req_if.sink       in_ch,
  ffza_rsp_if.source     out_ch,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata
);
  localparam int OW = ffza_pkg::OFF_W;
  localparam int AW = 34;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EVAL, S_WR2, S_MRD, S_MEVAL, S_OUT}
    state_t;

  state_t state_r;
  logic [31:0] base_r;
  ffza_pkg::req_t req_r;
  logic [OW-1:0] off_r, head_r, mj_r;
  logic          run_v_r;
  logic [OW-1:0] run_h_r;
  ffza_pkg::rsp_t rsp_r;
  logic           ov_r;
  logic                       we;
  logic [ffza_pkg::SLOT_W-1:0] waddr, raddr;
  ffza_pkg::zone_hdr_t         wdata, rdata;
  logic [ffza_pkg::SLOT_W-1:0] w2a_r;
  ffza_pkg::zone_hdr_t         w2d_r;
  logic                        ram_ready;
  logic [AW-1:0]               al_r, abs_al_r;

  ffza_hdr_ram u_ram (.clk, .rst_n, .we, .waddr, .wdata, .raddr, .rdata,
                      .init_done(ram_ready));

  // aligned start is formed while the header read is in flight, the rest after
  logic [OW-1:0] data_o, end_o, nz, split_sz;
  logic [AW-1:0] amask, abs_al, al, avail, rq, absd;
  logic fits, split;
  always_comb begin
    data_o = off_r + OW'(ffza_pkg::HEADER_BYTES);
    amask  = (AW'(1) << req_r.align_log2) - AW'(1);
    absd   = AW'(base_r) + AW'(data_o);
    abs_al = (absd + amask) & ~amask;
    al     = abs_al - AW'(base_r);
    end_o  = data_o + OW'(rdata.size);
    rq     = AW'(req_r.req_size);
    avail  = AW'(end_o) - al_r;
    fits   = rdata.is_free && (al_r <= AW'(end_o)) && (avail > rq);
    nz     = OW'(((al_r + rq + AW'(ffza_pkg::ZONE_ALIGN - 1))
                 & ~AW'(ffza_pkg::ZONE_ALIGN - 1)));
    split  = (avail - rq >= AW'(3 * ffza_pkg::HEADER_BYTES)) &&
             (AW'(nz) + AW'(ffza_pkg::HEADER_BYTES) <= AW'(end_o));
    split_sz = end_o - nz - OW'(ffza_pkg::HEADER_BYTES);
  end

  logic hit;
  assign hit = (AW'(base_r) + AW'(off_r) < AW'(req_r.free_address)) &&
               (AW'(req_r.free_address) < AW'(base_r) + AW'(end_o));

  logic [OW-1:0] rd_off;
  always_comb begin
    rd_off = (state_r == S_MRD || state_r == S_MEVAL) ? mj_r : off_r;
    raddr  = ffza_pkg::SLOT_W'(rd_off / ffza_pkg::ZONE_ALIGN);
  end

  // writes issued from the clocked block through registered strobes
  logic we_r; logic [ffza_pkg::SLOT_W-1:0] wa_r; ffza_pkg::zone_hdr_t wd_r;
  assign we = we_r; assign waddr = wa_r; assign wdata = wd_r;

  assign in_ch.ready = (state_r == S_IDLE) && !ov_r && ram_ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      base_r  <= '0;
      ov_r    <= 1'b0;
      we_r    <= 1'b0;
    end else begin
      we_r <= 1'b0;
      if (cfg_we) base_r <= cfg_wdata;
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          req_r   <= in_ch.data;
          off_r   <= '0;
          run_v_r <= 1'b0;
          rsp_r   <= '{status: (in_ch.data.kind == ffza_pkg::KIND_ALLOC) ?
                        ffza_pkg::ST_NOSPACE : ffza_pkg::ST_NOZONE,
                       address: '0, granted_size: '0};
          state_r <= S_RD;
        end
        S_RD: begin
          // read issued for off_r; hold the aligned start for the evaluation
          al_r     <= al;
          abs_al_r <= abs_al;
          if (off_r < OW'(ffza_pkg::WALK_LIMIT)) state_r <= S_EVAL;
          else state_r <= S_OUT;
        end
        S_EVAL: begin
          if (req_r.kind == ffza_pkg::KIND_ALLOC) begin
            if (fits) begin
              we_r <= 1'b1;
              wa_r <= ffza_pkg::SLOT_W'(off_r / ffza_pkg::ZONE_ALIGN);
              wd_r <= '{size: split ? ffza_pkg::SIZE_W'(nz - data_o) : rdata.size,
                        is_free: 1'b0};
              w2a_r <= ffza_pkg::SLOT_W'(nz / ffza_pkg::ZONE_ALIGN);
              w2d_r <= '{size: ffza_pkg::SIZE_W'(split_sz), is_free: 1'b1};
              rsp_r <= '{status: ffza_pkg::ST_ALLOC, address: abs_al_r[31:0],
                         granted_size: split ? ffza_pkg::SIZE_W'(nz - data_o)
                                             : rdata.size};
              state_r <= split ? S_WR2 : S_OUT;
            end else begin
              off_r <= end_o; state_r <= S_RD;
            end
          end else begin
            if (hit) begin
              we_r <= 1'b1;
              wa_r <= ffza_pkg::SLOT_W'(off_r / ffza_pkg::ZONE_ALIGN);
              wd_r <= '{size: rdata.size, is_free: 1'b1};
              head_r <= (rdata.is_free && run_v_r) ? run_h_r : off_r;
              mj_r   <= (rdata.is_free && run_v_r) ? run_h_r : off_r;
              rsp_r.status <= ffza_pkg::ST_FREED;
              state_r <= S_MRD;
            end else begin
              if (rdata.is_free && !run_v_r) begin
                run_v_r <= 1'b1; run_h_r <= off_r;
              end
              if (!rdata.is_free) run_v_r <= 1'b0;
              off_r <= end_o; state_r <= S_RD;
            end
          end
        end
        S_WR2: begin
          we_r <= 1'b1; wa_r <= w2a_r; wd_r <= w2d_r;
          state_r <= S_OUT;
        end
        S_MRD: begin
          if (mj_r < OW'(ffza_pkg::WALK_LIMIT) && !we_r) state_r <= S_MEVAL;
          else if (mj_r >= OW'(ffza_pkg::WALK_LIMIT)) begin
            we_r <= 1'b1;
            wa_r <= ffza_pkg::SLOT_W'(head_r / ffza_pkg::ZONE_ALIGN);
            wd_r <= '{size: ffza_pkg::SIZE_W'(mj_r - head_r -
                      OW'(ffza_pkg::HEADER_BYTES)), is_free: 1'b1};
            state_r <= S_OUT;
          end
        end
        S_MEVAL: begin
          if (rdata.is_free) begin
            mj_r <= mj_r + OW'(ffza_pkg::HEADER_BYTES) + OW'(rdata.size);
            state_r <= S_MRD;
          end else begin
            we_r <= 1'b1;
            wa_r <= ffza_pkg::SLOT_W'(head_r / ffza_pkg::ZONE_ALIGN);
            wd_r <= '{size: ffza_pkg::SIZE_W'(mj_r - head_r -
                      OW'(ffza_pkg::HEADER_BYTES)), is_free: 1'b1};
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!we_r) begin
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/ffza_hdr_ram.sv =====
`timescale 1ns / 1ps
// Header store: one write port, one registered read port, clearing pass after reset
module ffza_hdr_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [ffza_pkg::SLOT_W-1:0]   waddr,
  input  ffza_pkg::zone_hdr_t           wdata,
  input  logic [ffza_pkg::SLOT_W-1:0]   raddr,
  output ffza_pkg::zone_hdr_t           rdata,
  output logic                          init_done
);
  ffza_pkg::zone_hdr_t mem [ffza_pkg::ZONE_SLOTS];
  ffza_pkg::zone_hdr_t rd_r;
  logic [ffza_pkg::SLOT_W:0] clr_r;
  ffza_pkg::zone_hdr_t       clr_w;

  assign init_done = (clr_r == (ffza_pkg::SLOT_W+1)'(ffza_pkg::ZONE_SLOTS));
  assign rdata     = rd_r;

  // clear value: slot 0 free over the whole pool, others empty
  always_comb begin
    clr_w = '0;
    if (clr_r == '0) begin
      clr_w.size    = ffza_pkg::SIZE_W'(ffza_pkg::POOL_BYTES - ffza_pkg::HEADER_BYTES);
      clr_w.is_free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (!init_done) begin
      clr_r <= clr_r + (ffza_pkg::SLOT_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done) mem[clr_r[ffza_pkg::SLOT_W-1:0]] <= clr_w;
    else if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end
endmodule

// ===== rtl/ffza_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffza_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ffza_pkg::rsp_t out_data
);
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped while stalled")
  `ASSERT_IMP(a_no_take_pending, clk, rst_n, out_valid, !in_ready, "request taken while a result waits")
  `ASSERT_IMP(a_zero_fields, clk, rst_n, out_valid && out_data.status != ffza_pkg::ST_ALLOC, out_data.address == '0 && out_data.granted_size == '0, "unused fields not zero")
  `ASSERT_NXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken while busy")
endmodule

bind first_fit_zone_allocator ffza_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

// ===== bench/first_fit_zone_allocator_test.sv =====
`timescale 1ns / 1ps
module first_fit_zone_allocator_test;

  localparam int IDLE_LIMIT = 40000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 200; // extra wait once every response is back

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [31:0] cfg_wdata;

  ffza_req_if in_ch (clk);
  ffza_rsp_if out_ch (clk);

  first_fit_zone_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the header store and of the pool base register
  longint unsigned shadow_size [ffza_pkg::ZONE_SLOTS];
  bit              shadow_free [ffza_pkg::ZONE_SLOTS];
  longint unsigned shadow_base;

  ffza_pkg::rsp_t pending_rsp[$];  // predicted responses, oldest first
  logic [31:0]    granted_addr[$]; // recent grants, reused as free targets

  int n_sent, n_checked, n_errors, n_alloc_ok, n_nospace, n_freed, n_nozone;
  int burst_left;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic longint unsigned hdr_size_at(longint unsigned off);
    longint unsigned s;
    s = off / ffza_pkg::ZONE_ALIGN;
    return (s < ffza_pkg::ZONE_SLOTS) ? shadow_size[s] : 0;
  endfunction

  function automatic bit hdr_free_at(longint unsigned off);
    longint unsigned s;
    s = off / ffza_pkg::ZONE_ALIGN;
    return (s < ffza_pkg::ZONE_SLOTS) ? shadow_free[s] : 1'b0;
  endfunction

  function automatic void hdr_put(longint unsigned off, longint unsigned sz, bit fr);
    longint unsigned s;
    s = off / ffza_pkg::ZONE_ALIGN;
    if (s < ffza_pkg::ZONE_SLOTS) begin
      shadow_size[s] = sz;
      shadow_free[s] = fr;
    end
  endfunction

  function automatic void shadow_reset();
    for (int k = 0; k < ffza_pkg::ZONE_SLOTS; k++) begin
      shadow_size[k] = 0;
      shadow_free[k] = 1'b0;
    end
    shadow_size[0] = ffza_pkg::POOL_BYTES - ffza_pkg::HEADER_BYTES;
    shadow_free[0] = 1'b1;
    shadow_base = 0;
  endfunction

  // Apply one request to the shadow store and return the response it gives
  function automatic ffza_pkg::rsp_t predict_zone_op(ffza_pkg::req_t r);
    ffza_pkg::rsp_t res;
    longint unsigned off, sz, dstart, fin, a, rq, abs_al, al, nz, j, head;
    bit run_valid, fr;
    res.status = ffza_pkg::ST_NOSPACE;
    res.address = '0;
    res.granted_size = '0;
    off = 0;
    run_valid = 1'b0;
    head = 0;
    if (r.kind == ffza_pkg::KIND_ALLOC) begin
      a = 64'd1 << r.align_log2;
      rq = r.req_size;
      while (off < ffza_pkg::WALK_LIMIT) begin
        sz = hdr_size_at(off);
        dstart = off + ffza_pkg::HEADER_BYTES;
        fin = dstart + sz;
        if (!hdr_free_at(off)) begin
          off = fin;
          continue;
        end
        abs_al = ((shadow_base + dstart + a - 1) / a) * a;
        al = abs_al - shadow_base;
        // skip short zones and zones with no room past the aligned start
        if (al > fin || fin - al <= rq) begin
          off = fin;
          continue;
        end
        if (fin - al - rq >= 3 * ffza_pkg::HEADER_BYTES) begin
          nz = ((al + rq + ffza_pkg::ZONE_ALIGN - 1) / ffza_pkg::ZONE_ALIGN)
               * ffza_pkg::ZONE_ALIGN;
          if (nz + ffza_pkg::HEADER_BYTES <= fin) begin
            hdr_put(nz, fin - nz - ffza_pkg::HEADER_BYTES, 1'b1);
            sz = nz - dstart;
          end
        end
        hdr_put(off, sz, 1'b0);
        res.status = ffza_pkg::ST_ALLOC;
        res.address = abs_al[31:0];
        res.granted_size = sz[12:0];
        return res;
      end
      return res;
    end
    res.status = ffza_pkg::ST_NOZONE;
    while (off < ffza_pkg::WALK_LIMIT) begin
      fin = off + ffza_pkg::HEADER_BYTES + hdr_size_at(off);
      fr = hdr_free_at(off);
      if (fr && !run_valid) begin
        run_valid = 1'b1;
        head = off;
      end
      if (!fr) run_valid = 1'b0;
      if (shadow_base + off < r.free_address && r.free_address < shadow_base + fin) begin
        hdr_put(off, hdr_size_at(off), 1'b1);
        if (!run_valid) head = off;
        // absorb every following free zone into the run head
        j = head;
        while (j < ffza_pkg::WALK_LIMIT && hdr_free_at(j))
          j += ffza_pkg::HEADER_BYTES + hdr_size_at(j);
        hdr_put(head, j - head - ffza_pkg::HEADER_BYTES, 1'b1);
        res.status = ffza_pkg::ST_FREED;
        return res;
      end
      off = fin;
    end
    return res;
  endfunction

  // Drive one request word and hold it until the block takes it
  task automatic send_word(ffza_pkg::req_t r);
    ffza_pkg::rsp_t p;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_zone_op(r);
    pending_rsp.push_back(p);
    if (p.status == ffza_pkg::ST_ALLOC) begin
      granted_addr.push_back(p.address);
      if (granted_addr.size() > 64) void'(granted_addr.pop_front());
    end
    n_sent++;
    // burst bookkeeping: drop valid for a random gap between bursts
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  endtask

  function automatic ffza_pkg::req_t make_alloc(int unsigned sz, int unsigned al);
    ffza_pkg::req_t r;
    r.kind = ffza_pkg::KIND_ALLOC;
    r.req_size = sz[12:0];
    r.align_log2 = al[3:0];
    r.free_address = $urandom();
    return r;
  endfunction

  function automatic ffza_pkg::req_t make_free(logic [31:0] addr);
    ffza_pkg::req_t r;
    r.kind = ~ffza_pkg::KIND_ALLOC;
    r.req_size = 13'($urandom());
    r.align_log2 = 4'($urandom());
    r.free_address = addr;
    return r;
  endfunction

  // Drop valid, then hold off until every response is back and the block is quiet
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool_base(logic [31:0] v);
    drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    shadow_base = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Directed corners: sizes, alignments, null and foreign frees, double free
  task automatic test_directed();
    logic [31:0] first;
    set_pool_base(32'h0000_0000);
    send_word(make_alloc(0, 0));
    send_word(make_alloc(4096, 4));        // larger than the pool: no space
    send_word(make_alloc(8191, 15));
    send_word(make_alloc(100, 12));        // page alignment: no page-aligned start fits in the pool
    send_word(make_alloc(8, 4));
    send_word(make_alloc(3000, 4));
    send_word(make_free(32'h0));           // null free
    send_word(make_free(32'hFFFF_FFFF));   // foreign address
    first = granted_addr.size() ? granted_addr[0] : 32'h10;
    send_word(make_free(first));
    send_word(make_free(first));           // second free of the same address
    send_word(make_alloc(16, 4));
    send_word(make_alloc(40, 3));          // leftover large enough for a split
    send_word(make_alloc(1, 15));
    for (int k = 0; k < granted_addr.size(); k++) send_word(make_free(granted_addr[k]));
    send_word(make_alloc(4080, 0));        // whole pool's size: no space, a fit needs room past the request
    send_word(make_alloc(4079, 0));
    send_word(make_free(32'h0000_0010));
    send_word(make_alloc(4079, 0));
    send_word(make_free(32'h0000_0011));
  endtask

  // Random traffic: mostly small allocations and frees of granted blocks
  task automatic test_random_traffic(int count);
    ffza_pkg::req_t r;
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r = make_alloc(($urandom_range(0, 15) < 13) ? $urandom_range(0, 200)
                                                    : $urandom_range(0, 8191),
                       ($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 15));
      end else if (pick < 85 && granted_addr.size() != 0) begin
        r = make_free(granted_addr[$urandom_range(0, granted_addr.size() - 1)]
                      + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0));
      end else if (pick < 93) begin
        r = make_free(shadow_base[31:0] + $urandom_range(0, 4200));
      end else begin
        r = make_free($urandom());
      end
      send_word(r);
    end
  endtask

  // Receiver: stall pattern that switches among open, choppy and blocked stretches
  int stall_mode, stall_left;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Check each response against the oldest prediction; watch for a hang
  int idle_count;
  always @(posedge clk) begin
    ffza_pkg::rsp_t e;
    ffza_pkg::rsp_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none pending: status %0d address %h size %0d",
                 $time, got.status, got.address, got.granted_size);
        n_errors++;
      end else begin
        e = pending_rsp.pop_front();
        n_checked++;
        case (e.status)
          ffza_pkg::ST_ALLOC:   n_alloc_ok++;
          ffza_pkg::ST_NOSPACE: n_nospace++;
          ffza_pkg::ST_FREED:   n_freed++;
          default:              n_nozone++;
        endcase
        if (got.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
          n_errors++;
        end
        if (got.address !== e.address) begin
          $display("%0t: address expected %h actual %h", $time, e.address, got.address);
          n_errors++;
        end
        if (got.granted_size !== e.granted_size) begin
          $display("%0t: granted_size expected %0d actual %0d", $time, e.granted_size,
                   got.granted_size);
          n_errors++;
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_count = 0;
    end else if (rst_n) begin
      idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    stall_mode = 0;
    stall_left = 0;
    idle_count = 0;
    burst_left = 0;
    n_sent = 0;
    n_checked = 0;
    n_errors = 0;
    n_alloc_ok = 0;
    n_nospace = 0;
    n_freed = 0;
    n_nozone = 0;
    shadow_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(350);
    set_pool_base(32'h0001_0000);
    test_random_traffic(250);
    set_pool_base(32'hFFFF_F000);   // pool ends right at the 32-bit limit
    test_random_traffic(250);
    set_pool_base(32'hFFFF_FFFF);   // misaligned base, wraps past the limit
    test_random_traffic(250);
    set_pool_base($urandom() & 32'hFFFF_F000);
    test_random_traffic(250);
    set_pool_base(32'h0000_0000);
    test_random_traffic(250);
    drain();

    $display("covered %0d requests over six pool bases: %0d grants, %0d no space,",
             n_sent, n_alloc_ok, n_nospace);
    $display("  %0d frees, %0d frees outside any zone, %0d responses checked",
             n_freed, n_nozone, n_checked);
    if (n_errors == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== first_fit_zone_allocator.f =====
+incdir+rtl
rtl/ffza_pkg.sv
rtl/ffza_if.sv
rtl/ffza_hdr_ram.sv
rtl/first_fit_zone_allocator.sv
rtl/ffza_checker.sv
bench/first_fit_zone_allocator_test.sv
